@@ rtl/cspart_pkg.sv @@
package cspart_pkg;

  localparam int unsigned MAX_NODES_DEF = 8;
  localparam int unsigned LANES = 8;

  typedef logic [2:0] label_t;
  typedef label_t [LANES-1:0] lab_vec_t;

  typedef enum logic [1:0] {
    CMD_LOAD,
    CMD_SINGLE,
    CMD_GREEDY,
    CMD_NEXT
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK,
    ST_EXHAUSTED,
    ST_REJECTED
  } stat_e;

  localparam logic [1:0] REG_NODE_COUNT = 2'd0;
  localparam logic [1:0] REG_FUSABLE    = 2'd1;
  localparam logic [1:0] REG_FORBIDDEN  = 2'd2;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DISPATCH,
    S_WAIT,
    S_FINISH
  } state_e;

  typedef enum logic [1:0] {
    STORE_NONE,
    STORE_SINGLE,
    STORE_CAND,
    STORE_WORK
  } store_e;

  typedef struct packed {
    logic   latch;
    logic   chk_start;
    store_e store;
    logic   grd_take;
    logic   grd_skip;
    logic   stat_load;
    stat_e  stat;
    logic   out_load;
  } dp_cmd_t;

  typedef struct packed {
    cmd_e cmd;
    logic grd_end;
    logic next_fail;
    logic chk_done;
    logic chk_legal;
    logic out_free;
  } dp_sts_t;

  function automatic logic f_canon(lab_vec_t lab, logic [LANES-1:0] act);
    logic   ok;
    label_t mx;
    ok = (lab[0] == '0);
    mx = '0;
    for (int i = 1; i < LANES; i++) begin
      if (act[i]) begin
        if ({1'b0, lab[i]} > ({1'b0, mx} + 4'd1)) ok = 1'b0;
        if (lab[i] > mx) mx = lab[i];
      end
    end
    return ok;
  endfunction

  function automatic label_t f_maxlab(lab_vec_t lab, logic [LANES-1:0] act);
    label_t mx;
    mx = '0;
    for (int i = 0; i < LANES; i++) begin
      if (act[i] && (lab[i] > mx)) mx = lab[i];
    end
    return mx;
  endfunction

endpackage

@@ rtl/cspart_chk.sv @@
module cspart_chk (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  input  cspart_pkg::lab_vec_t                cand_i,
  input  logic [cspart_pkg::LANES-1:0]        act_i,
  input  logic [63:0]                         fus_i,
  input  logic [63:0]                         forb_i,
  output logic                                done_o,
  output logic                                legal_o,
  output cspart_pkg::lab_vec_t                cand_o
);
  import cspart_pkg::*;

  lab_vec_t         cand_q;
  logic [LANES-1:0] reach_q, reach_d, seed;
  logic             busy_q;
  logic             bad;

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      seed[i] = act_i[i];
      for (int k = 0; k < i; k++) begin
        if (cand_i[k] == cand_i[i]) seed[i] = 1'b0;
      end
    end
  end

  always_comb begin
    reach_d = reach_q;
    bad     = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      for (int j = 0; j < LANES; j++) begin
        if (act_i[i] && act_i[j] && (cand_q[i] == cand_q[j])) begin
          if (forb_i[i*LANES+j]) bad = 1'b1;
          if (reach_q[i] && (fus_i[i*LANES+j] || fus_i[j*LANES+i])) reach_d[j] = 1'b1;
        end
      end
    end
  end

  assign done_o  = busy_q && (reach_d == reach_q);
  assign legal_o = f_canon(cand_q, act_i) && !bad && (reach_q == act_i);
  assign cand_o  = cand_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
    end else if (start_i) begin
      busy_q <= 1'b1;
    end else if (done_o) begin
      busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      cand_q  <= cand_i;
      reach_q <= seed;
    end else if (busy_q) begin
      reach_q <= reach_d;
    end
  end

endmodule

@@ rtl/cspart_dp.sv @@
module cspart_dp #(
  parameter int unsigned MAX_NODES = cspart_pkg::MAX_NODES_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  cspart_pkg::dp_cmd_t    ctl_i,
  output cspart_pkg::dp_sts_t    sts_o,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_index_i,
  input  logic [63:0]            cfg_wdata_i,
  input  logic [1:0]             cmd_i,
  input  logic [23:0]            labels_in_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [23:0]            labels_out_o,
  output logic [3:0]             group_count_o,
  output logic [1:0]             status_o
);
  import cspart_pkg::*;

  logic [3:0]       node_count_q, n_eff;
  logic [63:0]      fus_q, forb_q;
  lab_vec_t         lab_q, work_q, labin_q, singles, merged, rt, chk_cand, cand_sel;
  lab_vec_t         lab_out;
  logic [LANES-1:0] act;
  logic [3:0]       src_q;
  logic [2:0]       dst_q;
  cmd_e             cmd_q;
  stat_e            stat_q;
  logic             out_valid_q;
  logic [23:0]      out_labels_q;
  logic [3:0]       out_groups_q;
  logic [1:0]       out_status_q;
  logic             rt_ok, chk_done, chk_legal;
  logic [2:0]       rt_idx;
  label_t           rt_mx, work_max, lab_max;

  always_comb begin
    if (node_count_q == '0) n_eff = 4'd1;
    else if (node_count_q > 4'(MAX_NODES)) n_eff = 4'(MAX_NODES);
    else n_eff = node_count_q;
    for (int i = 0; i < LANES; i++) act[i] = (4'(i) < n_eff);
  end

  always_comb begin
    for (int i = 0; i < LANES; i++) begin
      singles[i] = act[i] ? 3'(i) : 3'd0;
      lab_out[i] = act[i] ? lab_q[i] : 3'd0;
      if (!act[i]) merged[i] = '0;
      else if ({1'b0, work_q[i]} == src_q) merged[i] = dst_q;
      else if ({1'b0, work_q[i]} > src_q) merged[i] = work_q[i] - 3'd1;
      else merged[i] = work_q[i];
    end
  end

  always_comb begin
    rt_ok  = 1'b0;
    rt_idx = '0;
    for (int i = 1; i < LANES; i++) begin
      if (act[i] && (work_q[i] != '0)) begin
        rt_ok  = 1'b1;
        rt_idx = 3'(i);
      end
    end
    rt = work_q;
    rt[rt_idx] = work_q[rt_idx] - 3'd1;
    rt_mx = '0;
    for (int i = 0; i < LANES; i++) begin
      if ((3'(i) <= rt_idx) && (rt[i] > rt_mx)) rt_mx = rt[i];
    end
    for (int i = 0; i < LANES; i++) begin
      if (3'(i) > rt_idx) begin
        if (act[i]) begin
          rt_mx = rt_mx + 3'd1;
          rt[i] = rt_mx;
        end else begin
          rt[i] = '0;
        end
      end
    end
  end

  always_comb begin
    unique case (cmd_q)
      CMD_LOAD: begin
        for (int i = 0; i < LANES; i++) cand_sel[i] = act[i] ? labin_q[i] : 3'd0;
      end
      CMD_NEXT:   cand_sel = rt;
      CMD_GREEDY: cand_sel = merged;
      default:    cand_sel = merged;
    endcase
  end

  assign work_max = f_maxlab(work_q, act);
  assign lab_max  = f_maxlab(lab_q, act);

  cspart_chk u_chk (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ctl_i.chk_start),
    .cand_i  (cand_sel),
    .act_i   (act),
    .fus_i   (fus_q),
    .forb_i  (forb_q),
    .done_o  (chk_done),
    .legal_o (chk_legal),
    .cand_o  (chk_cand)
  );

  assign sts_o.cmd       = cmd_q;
  assign sts_o.grd_end   = (src_q > {1'b0, work_max});
  assign sts_o.next_fail = !f_canon(work_q, act) || !rt_ok;
  assign sts_o.chk_done  = chk_done;
  assign sts_o.chk_legal = chk_legal;
  assign sts_o.out_free  = !out_valid_q || out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= 4'd1;
      fus_q        <= '0;
      forb_q       <= '0;
      lab_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          REG_NODE_COUNT: node_count_q <= cfg_wdata_i[3:0];
          REG_FUSABLE:    fus_q        <= cfg_wdata_i;
          REG_FORBIDDEN:  forb_q       <= cfg_wdata_i;
          default: ;
        endcase
      end
      unique case (ctl_i.store)
        STORE_SINGLE: lab_q <= singles;
        STORE_CAND:   lab_q <= chk_cand;
        STORE_WORK:   lab_q <= work_q;
        default: ;
      endcase
      if (ctl_i.out_load) out_valid_q <= 1'b1;
      else if (out_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.latch) begin
      cmd_q   <= cmd_e'(cmd_i);
      labin_q <= labels_in_i;
      src_q   <= 4'd1;
      dst_q   <= '0;
      for (int i = 0; i < LANES; i++) begin
        work_q[i] <= (cmd_e'(cmd_i) == CMD_GREEDY) ? singles[i] : lab_q[i];
      end
    end else if (ctl_i.chk_start && (cmd_q == CMD_NEXT)) begin
      work_q <= rt;
    end else if (ctl_i.grd_take) begin
      work_q <= chk_cand;
      src_q  <= 4'd1;
      dst_q  <= '0;
    end else if (ctl_i.grd_skip) begin
      if (({1'b0, dst_q} + 4'd1) == src_q) begin
        src_q <= src_q + 4'd1;
        dst_q <= '0;
      end else begin
        dst_q <= dst_q + 3'd1;
      end
    end
    if (ctl_i.stat_load) stat_q <= ctl_i.stat;
    if (ctl_i.out_load) begin
      out_labels_q <= lab_out;
      out_groups_q <= {1'b0, lab_max} + 4'd1;
      out_status_q <= stat_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign labels_out_o  = out_labels_q;
  assign group_count_o = out_groups_q;
  assign status_o      = out_status_q;

`ifndef SYNTHESIS
  a_lab_canon : assert property (@(posedge clk_i) disable iff (!rst_ni)
    f_canon(lab_q, {LANES{1'b1}}))
    else $error("held labels not canonical");
  a_reject_load : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.out_load && (stat_q == ST_REJECTED)) |-> (cmd_q == CMD_LOAD))
    else $error("reject outside load");
  a_exhaust_next : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctl_i.out_load && (stat_q == ST_EXHAUSTED)) |-> (cmd_q == CMD_NEXT))
    else $error("exhaust outside next");
`endif

endmodule

@@ rtl/cspart_ctrl.sv @@
module cspart_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  cspart_pkg::dp_sts_t  sts_i,
  output cspart_pkg::dp_cmd_t  ctl_o
);
  import cspart_pkg::*;

  state_e st_q, st_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= S_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  always_comb begin
    st_d       = st_q;
    ctl_o      = '0;
    in_ready_o = 1'b0;
    unique case (st_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctl_o.latch = 1'b1;
          st_d        = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        unique case (sts_i.cmd)
          CMD_LOAD: begin
            ctl_o.chk_start = 1'b1;
            st_d            = S_WAIT;
          end
          CMD_SINGLE: begin
            ctl_o.store     = STORE_SINGLE;
            ctl_o.stat_load = 1'b1;
            ctl_o.stat      = ST_OK;
            st_d            = S_FINISH;
          end
          CMD_GREEDY: begin
            if (sts_i.grd_end) begin
              ctl_o.store     = STORE_WORK;
              ctl_o.stat_load = 1'b1;
              ctl_o.stat      = ST_OK;
              st_d            = S_FINISH;
            end else begin
              ctl_o.chk_start = 1'b1;
              st_d            = S_WAIT;
            end
          end
          default: begin
            if (sts_i.next_fail) begin
              ctl_o.stat_load = 1'b1;
              ctl_o.stat      = ST_EXHAUSTED;
              st_d            = S_FINISH;
            end else begin
              ctl_o.chk_start = 1'b1;
              st_d            = S_WAIT;
            end
          end
        endcase
      end
      S_WAIT: begin
        if (sts_i.chk_done) begin
          unique case (sts_i.cmd)
            CMD_LOAD: begin
              ctl_o.stat_load = 1'b1;
              if (sts_i.chk_legal) begin
                ctl_o.store = STORE_CAND;
                ctl_o.stat  = ST_OK;
              end else begin
                ctl_o.stat  = ST_REJECTED;
              end
              st_d = S_FINISH;
            end
            CMD_GREEDY: begin
              if (sts_i.chk_legal) ctl_o.grd_take = 1'b1;
              else ctl_o.grd_skip = 1'b1;
              st_d = S_DISPATCH;
            end
            CMD_NEXT: begin
              if (sts_i.chk_legal) begin
                ctl_o.store     = STORE_WORK;
                ctl_o.stat_load = 1'b1;
                ctl_o.stat      = ST_OK;
                st_d            = S_FINISH;
              end else begin
                st_d = S_DISPATCH;
              end
            end
            default: st_d = S_FINISH;
          endcase
        end
      end
      default: begin
        if (sts_i.out_free) begin
          ctl_o.out_load = 1'b1;
          st_d           = S_IDLE;
        end
      end
    endcase
  end

endmodule

@@ rtl/constrained_set_partition_stepper.sv @@
// Sequencing: load runs one connectivity check; singletons only store; greedy merge and
// next-legal run one connectivity check per candidate, each preceded by a dispatch step.
// One beat in flight: a new beat is accepted only in idle, after the previous result has
// been loaded into the output register, which waits while that register is still full.
// Reset: asynchronous, active low; labels clear to zero, node count 1, masks 0.
module constrained_set_partition_stepper #(
  parameter int unsigned MAX_NODES = cspart_pkg::MAX_NODES_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [63:0] cfg_wdata_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  cmd_i,
  input  logic [23:0] labels_in_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [23:0] labels_out_o,
  output logic [3:0]  group_count_o,
  output logic [1:0]  status_o
);
  import cspart_pkg::*;

  dp_cmd_t ctl;
  dp_sts_t sts;

  cspart_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .sts_i      (sts),
    .ctl_o      (ctl)
  );

  cspart_dp #(
    .MAX_NODES (MAX_NODES)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .ctl_i         (ctl),
    .sts_o         (sts),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .cmd_i         (cmd_i),
    .labels_in_i   (labels_in_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .labels_out_o  (labels_out_o),
    .group_count_o (group_count_o),
    .status_o      (status_o)
  );

endmodule
